### hdl/qrs_pkg.sv
// Shared types, constants and width helpers of the quadratic root solver.
`timescale 1ns / 1ps
package qrs_pkg;
	localparam int VALUE_W = 48;
	localparam int DISC_W  = 34;

	typedef enum logic [1:0] {
		CLS_REAL    = 2'd0,
		CLS_REPEAT  = 2'd1,
		CLS_COMPLEX = 2'd2,
		CLS_DEGEN   = 2'd3
	} root_class_t;

	typedef struct packed {
		logic load_in;
		logic mul;
		logic disc;
		logic sq_init;
		logic sq_step;
		logic dv_init;
		logic dv_sel;
		logic dv_step;
		logic out_load;
	} qrs_cmd_t;

	// Width of the exact discriminant.
	function automatic int disc_w(input int cw);
		return 2 * cw + 2;
	endfunction

	// Width of the integer root of |d| shifted left by twice the fraction bits.
	function automatic int root_w(input int cw, input int f);
		return cw + 1 + f;
	endfunction

	// Width of a signed numerator -b*2^f plus or minus the root.
	function automatic int num_w(input int cw, input int f);
		return cw + f + 3;
	endfunction
endpackage

### hdl/qrs_if.sv
// Valid/ready channel interfaces for coefficient input and root output.
`timescale 1ns / 1ps
interface qrs_in_if #(parameter int COEF_WIDTH = 16);
	logic                         valid;
	logic                         ready;
	logic signed [COEF_WIDTH-1:0] coef_square;
	logic signed [COEF_WIDTH-1:0] coef_linear;
	logic signed [COEF_WIDTH-1:0] coef_constant;
	modport source(output valid, coef_square, coef_linear, coef_constant, input ready);
	modport sink(input valid, coef_square, coef_linear, coef_constant, output ready);
endinterface

interface qrs_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         root_class;
	logic signed [47:0] first_value;
	logic signed [47:0] second_value;
	logic signed [33:0] discriminant_out;
	modport source(output valid, root_class, first_value, second_value, discriminant_out,
		input ready);
	modport sink(input valid, root_class, first_value, second_value, discriminant_out,
		output ready);
endinterface

### hdl/quadratic_root_solver.sv
// Quadratic root solver: one result per coefficient set, from a digit-serial root of
// RW = COEF_WIDTH+FRAC_BITS+1 root digits and the one shared restoring divider, run
// twice for NW = COEF_WIDTH+FRAC_BITS+3 quotient bits each. No new set is taken while
// one is in progress. A new set is taken after the result enters the output register,
// even while that result still waits for transfer. Reset clears the sequencer and the
// output valid flag; the datapath registers are not reset.
`timescale 1ns / 1ps
module quadratic_root_solver import qrs_pkg::*; #(
	parameter int COEF_WIDTH = 16,
	parameter int FRAC_BITS  = 16
) (
	input logic     clk,
	input logic     arst_n,
	qrs_in_if.sink  in_ch,
	qrs_out_if.source out_ch
);
	qrs_cmd_t cmd;

	qrs_ctrl #(.COEF_WIDTH(COEF_WIDTH), .FRAC_BITS(FRAC_BITS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.cmd       (cmd)
	);

	qrs_dp #(.COEF_WIDTH(COEF_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk              (clk),
		.cmd              (cmd),
		.coef_square      (in_ch.coef_square),
		.coef_linear      (in_ch.coef_linear),
		.coef_constant    (in_ch.coef_constant),
		.root_class       (out_ch.root_class),
		.first_value      (out_ch.first_value),
		.second_value     (out_ch.second_value),
		.discriminant_out (out_ch.discriminant_out)
	);
endmodule

### hdl/qrs_ctrl.sv
// Sequencing state machine of the quadratic root solver.
`timescale 1ns / 1ps
module qrs_ctrl import qrs_pkg::*; #(
	parameter int COEF_WIDTH = 16,
	parameter int FRAC_BITS  = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     out_ready,
	output logic     out_valid,
	output qrs_cmd_t cmd
);
	localparam int RW    = root_w(COEF_WIDTH, FRAC_BITS);
	localparam int NW    = num_w(COEF_WIDTH, FRAC_BITS);
	localparam int CNT_W = $clog2(NW);

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_DISC, ST_SQ_INIT, ST_SQRT, ST_DV_INIT, ST_DIV, ST_DONE
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               sel_q;
	logic               out_valid_q;
	logic               emit;

	assign emit      = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.load_in  = (state_q == ST_IDLE) && in_valid;
		cmd.mul      = (state_q == ST_MUL);
		cmd.disc     = (state_q == ST_DISC);
		cmd.sq_init  = (state_q == ST_SQ_INIT);
		cmd.sq_step  = (state_q == ST_SQRT);
		cmd.dv_init  = (state_q == ST_DV_INIT);
		cmd.dv_sel   = sel_q;
		cmd.dv_step  = (state_q == ST_DIV);
		cmd.out_load = emit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			sel_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// The output register drains independently of the state machine.
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_MUL;
				end
				ST_MUL: state_q <= ST_DISC;
				ST_DISC: state_q <= ST_SQ_INIT;
				ST_SQ_INIT: begin
					cnt_q   <= CNT_W'(RW - 1);
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (cnt_q == '0) begin
						sel_q   <= 1'b0;
						state_q <= ST_DV_INIT;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_DV_INIT: begin
					cnt_q   <= CNT_W'(NW - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						if (!sel_q) begin
							sel_q   <= 1'b1;
							state_q <= ST_DV_INIT;
						end else begin
							state_q <= ST_DONE;
						end
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_DONE: begin
					if (emit)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### hdl/qrs_dp.sv
// Datapath: products, discriminant, digit-serial root and shared restoring divider.
`timescale 1ns / 1ps
module qrs_dp import qrs_pkg::*; #(
	parameter int COEF_WIDTH = 16,
	parameter int FRAC_BITS  = 16
) (
	input  logic                         clk,
	input  qrs_cmd_t                     cmd,
	input  logic signed [COEF_WIDTH-1:0] coef_square,
	input  logic signed [COEF_WIDTH-1:0] coef_linear,
	input  logic signed [COEF_WIDTH-1:0] coef_constant,
	output logic [1:0]                   root_class,
	output logic signed [VALUE_W-1:0]    first_value,
	output logic signed [VALUE_W-1:0]    second_value,
	output logic signed [DISC_W-1:0]     discriminant_out
);
	localparam int CW = COEF_WIDTH;
	localparam int DW = disc_w(CW);
	localparam int MW = DW + 2 * FRAC_BITS;
	localparam int RW = root_w(CW, FRAC_BITS);
	localparam int NW = num_w(CW, FRAC_BITS);

	logic signed [CW-1:0]   a_q, b_q, c_q;
	logic signed [2*CW-1:0] bb_q, ac_q;
	logic signed [DW-1:0]   d_q;
	logic [MW-1:0]          opnd_q;
	logic [RW+1:0]          srem_q;
	logic [RW-1:0]          root_q;
	logic [NW-1:0]          dvq_q;
	logic [CW:0]            dvr_q;
	logic                   qneg_q;
	logic signed [NW-1:0]   v1_q;

	logic [DW-1:0]          d_mag;
	logic [RW+3:0]          srem2, strial;
	logic signed [NW-1:0]   negb, rval, num;
	logic [NW-1:0]          num_mag;
	logic signed [CW:0]     den;
	logic [CW:0]            den_mag;
	logic [CW+1:0]          drem2, dden;
	logic signed [NW-1:0]   quot;
	root_class_t            cls;

	assign d_mag  = d_q[DW-1] ? DW'(-d_q) : d_q;
	assign srem2  = {srem_q, opnd_q[MW-1:MW-2]};
	assign strial = {2'b00, root_q, 2'b01};

	assign negb = -(NW'(b_q) <<< FRAC_BITS);
	assign rval = signed'(NW'(root_q));

	always_comb begin
		priority if (a_q == '0)
			cls = CLS_DEGEN;
		else if (d_q == '0)
			cls = CLS_REPEAT;
		else if (d_q[DW-1])
			cls = CLS_COMPLEX;
		else
			cls = CLS_REAL;
	end

	always_comb begin
		if (!cmd.dv_sel) begin
			num = (cls == CLS_REAL) ? negb + rval : negb;
		end else begin
			unique case (cls)
				CLS_REAL:    num = negb - rval;
				CLS_COMPLEX: num = rval;
				default:     num = '0;
			endcase
		end
	end

	assign num_mag = num[NW-1] ? NW'(-num) : NW'(num);
	assign den     = (CW + 1)'(a_q) <<< 1;
	assign den_mag = den[CW] ? (CW + 1)'(-den) : (CW + 1)'(den);
	assign drem2   = {dvr_q, dvq_q[NW-1]};
	assign dden    = {1'b0, den_mag};
	assign quot    = qneg_q ? -signed'(dvq_q) : signed'(dvq_q);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			a_q <= coef_square;
			b_q <= coef_linear;
			c_q <= coef_constant;
		end
		if (cmd.mul) begin
			bb_q <= b_q * b_q;
			ac_q <= a_q * c_q;
		end
		if (cmd.disc)
			d_q <= DW'(bb_q) - (DW'(ac_q) <<< 2);
		if (cmd.sq_init) begin
			opnd_q <= {d_mag, (2 * FRAC_BITS)'(0)};
			srem_q <= '0;
			root_q <= '0;
		end
		if (cmd.sq_step) begin
			opnd_q <= opnd_q << 2;
			if (srem2 >= strial) begin
				srem_q <= (RW + 2)'(srem2 - strial);
				root_q <= {root_q[RW-2:0], 1'b1};
			end else begin
				srem_q <= (RW + 2)'(srem2);
				root_q <= {root_q[RW-2:0], 1'b0};
			end
		end
		if (cmd.dv_init) begin
			// The second division overwrites the quotient, so keep the first.
			if (cmd.dv_sel)
				v1_q <= quot;
			dvq_q  <= num_mag;
			dvr_q  <= '0;
			qneg_q <= num[NW-1] ^ den[CW];
		end
		if (cmd.dv_step) begin
			if (drem2 >= dden) begin
				dvr_q <= (CW + 1)'(drem2 - dden);
				dvq_q <= {dvq_q[NW-2:0], 1'b1};
			end else begin
				dvr_q <= (CW + 1)'(drem2);
				dvq_q <= {dvq_q[NW-2:0], 1'b0};
			end
		end
		if (cmd.out_load) begin
			root_class       <= cls;
			first_value      <= (cls == CLS_DEGEN) ? '0 : VALUE_W'(v1_q);
			second_value     <= (cls == CLS_DEGEN) ? '0 : VALUE_W'(quot);
			discriminant_out <= DISC_W'(d_q);
		end
	end
endmodule

### sim/quadratic_root_solver_test.sv
// Self-checking testbench of the quadratic root solver with its own root predictor.
`timescale 1ns / 1ps
module quadratic_root_solver_test;
	import qrs_pkg::*;

	typedef struct packed {
		root_class_t        root_class;
		logic signed [47:0] first_value;
		logic signed [47:0] second_value;
		logic signed [33:0] discriminant_out;
	} roots_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	qrs_in_if #(.COEF_WIDTH(16)) in_ch ();
	qrs_out_if out_ch ();

	quadratic_root_solver #(.COEF_WIDTH(16), .FRAC_BITS(16)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always #6 clk = ~clk;

	roots_t pending_roots[$];
	int     fail_count = 0;
	int     sent_count = 0;
	int     checked_count = 0;
	int     class_seen[4] = '{0, 0, 0, 0};
	bit     hold_off = 1'b0;
	bit     no_stall = 1'b0;
	int     burst_left = 0;

	// Floor square root of m shifted left by 32, digit by digit over 128 bits.
	function automatic logic [63:0] shifted_isqrt(input logic [63:0] m);
		logic [127:0] v;
		logic [63:0]  root;
		logic [65:0]  rem;
		logic [65:0]  trial;
		v = {64'd0, m} << 32;
		root = '0;
		rem = '0;
		for (int p = 126; p >= 0; p -= 2) begin
			rem = (rem << 2) | {64'd0, v[p+1], v[p]};
			root = root << 1;
			trial = {1'b0, root, 1'b1};
			if (rem >= trial) begin
				rem = rem - trial;
				root[0] = 1'b1;
			end
		end
		return root;
	endfunction

	function automatic roots_t solve_roots(input logic signed [15:0] ca,
		input logic signed [15:0] cb, input logic signed [15:0] cc);
		roots_t res;
		longint a, b, c, d, negb, den, r, v1, v2;
		a = longint'(ca);
		b = longint'(cb);
		c = longint'(cc);
		d = b * b - 4 * a * c;
		negb = -b * 65536;
		den = 2 * a;
		v1 = 0;
		v2 = 0;
		if (a == 0) begin
			res.root_class = CLS_DEGEN;
		end else if (d > 0) begin
			r = shifted_isqrt(d);
			res.root_class = CLS_REAL;
			v1 = (negb + r) / den;
			v2 = (negb - r) / den;
		end else if (d == 0) begin
			res.root_class = CLS_REPEAT;
			v1 = negb / den;
		end else begin
			r = shifted_isqrt(-d);
			res.root_class = CLS_COMPLEX;
			v1 = negb / den;
			v2 = r / den;
		end
		res.first_value = v1[47:0];
		res.second_value = v2[47:0];
		res.discriminant_out = d[33:0];
		return res;
	endfunction

	// Sends one coefficient set; bursts of random length with random gaps between them.
	task automatic send_coefs(input logic signed [15:0] ca, input logic signed [15:0] cb,
		input logic signed [15:0] cc);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 150)) : 0;
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 8);
		end
		in_ch.valid <= 1'b1;
		in_ch.coef_square <= ca;
		in_ch.coef_linear <= cb;
		in_ch.coef_constant <= cc;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		pending_roots.push_back(solve_roots(ca, cb, cc));
		sent_count++;
		burst_left--;
		@(negedge clk);
	endtask

	task automatic go_idle();
		in_ch.valid <= 1'b0;
		burst_left = 0;
		@(negedge clk);
	endtask

	// Receiver stall pattern.
	always @(negedge clk) begin
		if (hold_off)
			out_ch.ready <= 1'b0;
		else if (no_stall)
			out_ch.ready <= 1'b1;
		else
			out_ch.ready <= ($urandom_range(0, 99) < 65);
	end

	always @(posedge clk) begin
		roots_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_roots.size() == 0) begin
				$error("result transfer with no expectation waiting");
				fail_count++;
			end else begin
				want = pending_roots.pop_front();
				checked_count++;
				class_seen[want.root_class]++;
				if (out_ch.root_class !== want.root_class) begin
					$error("root_class expected %0d got %0d", want.root_class,
						out_ch.root_class);
					fail_count++;
				end
				if (out_ch.first_value !== want.first_value) begin
					$error("first_value expected %0d got %0d", want.first_value,
						out_ch.first_value);
					fail_count++;
				end
				if (out_ch.second_value !== want.second_value) begin
					$error("second_value expected %0d got %0d", want.second_value,
						out_ch.second_value);
					fail_count++;
				end
				if (out_ch.discriminant_out !== want.discriminant_out) begin
					$error("discriminant_out expected %0d got %0d",
						want.discriminant_out, out_ch.discriminant_out);
					fail_count++;
				end
			end
		end
	end

	task automatic test_directed();
		no_stall = 1'b1;
		send_coefs(16'sd1, -16'sd3, 16'sd2);
		send_coefs(16'sd1, 16'sd2, 16'sd1);
		send_coefs(16'sd1, 16'sd0, 16'sd1);
		send_coefs(16'sd0, 16'sd5, 16'sd7);
		send_coefs(16'sd0, 16'sd0, 16'sd0);
		send_coefs(-16'sd2, 16'sd3, 16'sd5);
		send_coefs(-16'sd1, 16'sd0, -16'sd4);
		send_coefs(-16'sd32768, -16'sd32768, 16'sd32767);
		send_coefs(16'sd32767, -16'sd32768, -16'sd32768);
		send_coefs(16'sd32767, 16'sd32767, 16'sd32767);
		send_coefs(-16'sd32768, -16'sd32768, -16'sd32768);
		send_coefs(-16'sd32768, 16'sd0, 16'sd32767);
		send_coefs(16'sd1, -16'sd32768, 16'sd0);
		send_coefs(-16'sd32768, 16'sd32767, 16'sd0);
		send_coefs(16'sd1, -16'sd32768, -16'sd32768);
		send_coefs(16'sd4, 16'sd4, 16'sd1);
		send_coefs(-16'sd1, 16'sd1, 16'sd0);
		send_coefs(16'sd2, 16'sd1, 16'sd3);
		go_idle();
		no_stall = 1'b0;
	endtask

	// Long receiver hold-off while the sender keeps offering sets.
	task automatic test_backpressure();
		fork
			begin
				hold_off = 1'b1;
				repeat (1200) @(negedge clk);
				hold_off = 1'b0;
			end
			repeat (12) send_coefs(16'($urandom), 16'($urandom), 16'($urandom));
		join
		go_idle();
	endtask

	task automatic test_random(input int count);
		logic signed [15:0] ca, cb, cc;
		int k;
		int j;
		for (int i = 0; i < count; i++) begin
			ca = 16'($urandom);
			cb = 16'($urandom);
			cc = 16'($urandom);
			case ($urandom_range(0, 7))
				0: ca = 16'sd0;
				1: begin
					// b = 2kj and c = kj^2 give a zero discriminant.
					k = $urandom_range(1, 180);
					if ($urandom_range(0, 1)) k = -k;
					j = int'($urandom_range(0, 26)) - 13;
					ca = 16'(k);
					cb = 16'(2 * k * j);
					cc = 16'(k * j * j);
				end
				2: begin
					ca = $signed(16'($urandom_range(0, 15))) - 16'sd8;
					cb = $signed(16'($urandom_range(0, 31))) - 16'sd16;
					cc = $signed(16'($urandom_range(0, 31))) - 16'sd16;
				end
				3: begin
					ca = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
				end
				default: ;
			endcase
			send_coefs(ca, cb, cc);
		end
		go_idle();
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.coef_square = '0;
		in_ch.coef_linear = '0;
		in_ch.coef_constant = '0;
		out_ch.ready = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_backpressure();
		test_random(1280);
		wait (pending_roots.size() == 0);
		repeat (250) @(posedge clk);
		$display("Sent %0d coefficient sets and checked %0d results.", sent_count,
			checked_count);
		$display("Classes seen: real %0d, repeated %0d, complex %0d, degenerate %0d.",
			class_seen[0], class_seen[1], class_seen[2], class_seen[3]);
		if (fail_count == 0 && pending_roots.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#20ms;
		$display("Test completed with failures");
		$finish;
	end
endmodule

### quadratic_root_solver.f
hdl/qrs_pkg.sv
hdl/qrs_if.sv
hdl/qrs_ctrl.sv
hdl/qrs_dp.sv
hdl/quadratic_root_solver.sv
sim/quadratic_root_solver_test.sv
